// ----- sv/qda_pkg.sv -----
package qda_pkg;

    localparam int EDGE_W   = 16;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETENT_CAP     = 3'd0,
        REG_FAST_THRESHOLD = 3'd1,
        REG_MID_THRESHOLD  = 3'd2,
        REG_SLOW_THRESHOLD = 3'd3,
        REG_FAST_GAIN      = 3'd4,
        REG_MID_GAIN       = 3'd5,
        REG_SLOW_GAIN      = 3'd6
    } t_reg_idx;

    localparam logic [7:0] RST_DETENT_CAP     = 8'd12;
    localparam logic [7:0] RST_FAST_THRESHOLD = 8'd8;
    localparam logic [7:0] RST_MID_THRESHOLD  = 8'd4;
    localparam logic [7:0] RST_SLOW_THRESHOLD = 8'd2;
    localparam logic [6:0] RST_FAST_GAIN      = 7'd10;
    localparam logic [6:0] RST_MID_GAIN       = 7'd5;
    localparam logic [6:0] RST_SLOW_GAIN      = 7'd2;
    localparam logic [1:0] RST_PHASE          = 2'b11;

    typedef enum logic [1:0] {
        DELTA_NONE = 2'd0,
        DELTA_INC  = 2'd1,
        DELTA_DEC  = 2'd2
    } t_delta;

    typedef struct packed {
        logic   poll;
        t_delta delta;
    } t_entry;

    typedef struct packed {
        logic [7:0] detent_cap;
        logic [7:0] fast_threshold;
        logic [7:0] mid_threshold;
        logic [7:0] slow_threshold;
        logic [6:0] fast_gain;
        logic [6:0] mid_gain;
        logic [6:0] slow_gain;
    } t_cfg;

    localparam t_delta PHASE_DELTA [16] = '{
        DELTA_NONE, DELTA_DEC,  DELTA_INC,  DELTA_NONE,
        DELTA_INC,  DELTA_NONE, DELTA_NONE, DELTA_DEC,
        DELTA_DEC,  DELTA_NONE, DELTA_NONE, DELTA_INC,
        DELTA_NONE, DELTA_INC,  DELTA_DEC,  DELTA_NONE
    };

endpackage

// ----- sv/qda_front.sv -----
module qda_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_kind,
    input  logic            i_phase_a,
    input  logic            i_phase_b,
    output logic            o_push,
    output qda_pkg::t_entry o_entry
);
    import qda_pkg::*;

    logic [1:0] r_last_phase;
    logic [1:0] n_last_phase;
    logic [1:0] phase;
    t_delta     delta;

    assign phase = {i_phase_b, i_phase_a};
    assign delta = PHASE_DELTA[{r_last_phase, phase}];

    always_comb begin
        n_last_phase  = r_last_phase;
        o_push        = 1'b0;
        o_entry.poll  = i_kind;
        o_entry.delta = delta;
        if (i_accept) begin
            if (i_kind) begin
                o_push        = 1'b1;
                o_entry.delta = DELTA_NONE;
            end else if (phase != r_last_phase) begin
                n_last_phase = phase;
                o_push       = (delta != DELTA_NONE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= RST_PHASE;
        end else begin
            r_last_phase <= n_last_phase;
        end
    end

endmodule

// ----- sv/qda_queue.sv -----
module qda_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qda_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output qda_pkg::t_entry o_entry
);
    import qda_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/qda_back.sv -----
module qda_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qda_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  qda_pkg::t_entry   i_q_entry,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [7:0] o_step,
    output logic              o_moved
);
    import qda_pkg::*;

    localparam int SUM_W = EDGE_W + 1;
    localparam logic signed [EDGE_W-1:0] EDGE_MAX = {1'b0, {(EDGE_W-1){1'b1}}};
    localparam logic signed [EDGE_W-1:0] EDGE_MIN = {1'b1, {(EDGE_W-1){1'b0}}};

    logic signed [EDGE_W-1:0] r_edge;
    logic signed [EDGE_W-1:0] n_edge;
    logic signed [2:0]        r_rem;
    logic signed [2:0]        n_rem;
    logic                     r_out_valid;
    logic signed [7:0]        r_step;
    logic                     r_moved;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  adj;
    logic signed [SUM_W-1:0]  det_full;
    logic signed [SUM_W-1:0]  rem_full;
    logic [SUM_W-1:0]         amount;
    logic [7:0]               capped;
    logic [6:0]               mag;
    logic                     big;
    logic signed [7:0]        step;
    logic                     out_free;
    logic                     load;

    always_comb begin
        sum      = $signed({{(SUM_W-3){r_rem[2]}}, r_rem})
                 + $signed({r_edge[EDGE_W-1], r_edge});
        adj      = sum[SUM_W-1] ? sum + SUM_W'(3) : sum;
        det_full = adj >>> 2;
        rem_full = sum - (det_full <<< 2);
        big      = (det_full != '0);
        amount   = det_full[SUM_W-1] ? SUM_W'(-det_full) : SUM_W'(det_full);
        capped   = (amount > SUM_W'(i_cfg.detent_cap)) ? i_cfg.detent_cap : amount[7:0];
        priority if (capped >= i_cfg.fast_threshold) begin
            mag = i_cfg.fast_gain;
        end else if (capped >= i_cfg.mid_threshold) begin
            mag = i_cfg.mid_gain;
        end else if (capped >= i_cfg.slow_threshold) begin
            mag = i_cfg.slow_gain;
        end else begin
            mag = 7'd1;
        end
        if (!big) begin
            step = '0;
        end else if (det_full[SUM_W-1]) begin
            step = -$signed({1'b0, mag});
        end else begin
            step = $signed({1'b0, mag});
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && (!i_q_entry.poll || out_free);
    assign load     = o_pop && i_q_entry.poll;

    always_comb begin
        n_edge = r_edge;
        n_rem  = r_rem;
        if (o_pop) begin
            if (i_q_entry.poll) begin
                n_edge = '0;
                n_rem  = rem_full[2:0];
            end else begin
                unique case (i_q_entry.delta)
                    DELTA_INC: begin
                        if (r_edge != EDGE_MAX) n_edge = r_edge + EDGE_W'(1);
                    end
                    DELTA_DEC: begin
                        if (r_edge != EDGE_MIN) n_edge = r_edge - EDGE_W'(1);
                    end
                    default: begin
                        n_edge = r_edge;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge      <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_edge <= n_edge;
            r_rem  <= n_rem;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_step  <= step;
            r_moved <= big;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step      = r_step;
    assign o_moved     = r_moved;

endmodule

// ----- sv/quadrature_detent_accelerator.sv -----
// Quadrature encoder decoder with detent acceleration. Requests are pin samples
// (kind 0) or polls (kind 1); each poll returns one step/moved result, pin samples
// return nothing. The block takes one request per cycle: a front stage decodes
// pin transitions and queues edges and polls in a four-entry queue, and a back
// stage retires queued entries into the edge count or, for a poll, into the output
// register, one entry per cycle while no poll waits on an untaken result. A poll
// with nothing queued ahead of it is written into the queue, then loaded into the
// output register. The input stalls only while the queue is full, which happens
// if results sit untaken. Write configuration only while no request is in flight.
module quadrature_detent_accelerator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qda_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qda_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic                             i_phase_a,
    input  logic                             i_phase_b,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [7:0]                o_step,
    output logic                             o_moved
);
    import qda_pkg::*;

    t_cfg   r_cfg;
    t_entry push_entry;
    t_entry head_entry;
    logic   accept;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detent_cap     <= RST_DETENT_CAP;
            r_cfg.fast_threshold <= RST_FAST_THRESHOLD;
            r_cfg.mid_threshold  <= RST_MID_THRESHOLD;
            r_cfg.slow_threshold <= RST_SLOW_THRESHOLD;
            r_cfg.fast_gain      <= RST_FAST_GAIN;
            r_cfg.mid_gain       <= RST_MID_GAIN;
            r_cfg.slow_gain      <= RST_SLOW_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DETENT_CAP:     r_cfg.detent_cap     <= i_cfg_data;
                REG_FAST_THRESHOLD: r_cfg.fast_threshold <= i_cfg_data;
                REG_MID_THRESHOLD:  r_cfg.mid_threshold  <= i_cfg_data;
                REG_SLOW_THRESHOLD: r_cfg.slow_threshold <= i_cfg_data;
                REG_FAST_GAIN:      r_cfg.fast_gain      <= i_cfg_data[6:0];
                REG_MID_GAIN:       r_cfg.mid_gain       <= i_cfg_data[6:0];
                REG_SLOW_GAIN:      r_cfg.slow_gain      <= i_cfg_data[6:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    qda_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_kind    (i_kind),
        .i_phase_a (i_phase_a),
        .i_phase_b (i_phase_b),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    qda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    qda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_step      (o_step),
        .o_moved     (o_moved)
    );

endmodule
